>>> hdl/spge_pkg.sv
// ----------------------------------------------------------------------------
// spge_pkg
// Shared types and constants of the softened potential grid evaluator.
// ----------------------------------------------------------------------------
package spge_pkg;

  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_ADD   = 2'd1;
  localparam logic [1:0] CMD_EVAL  = 2'd2;
  localparam logic [1:0] CMD_RSVD  = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  localparam logic [1:0] REG_GRAV = 2'd0;
  localparam logic [1:0] REG_HALF = 2'd1;
  localparam logic [1:0] REG_STEP = 2'd2;

  localparam int unsigned CORDIC_ITERS = 17;
  localparam logic [63:0] SOFTEN_Q32   = 64'd429496730;
  localparam logic [16:0] ANGLE_MAX    = 17'd102944;
  localparam logic [19:0] HEIGHT_GAIN  = 20'd625823;
  localparam logic [20:0] HEIGHT_MAX   = 21'd983040;
  // ceil(2^34 / 5): (n * DIV5_RECIP) >> 34 is floor(n / 5) for any 32-bit n
  localparam logic [31:0] DIV5_RECIP   = 32'hCCCC_CCCD;

  function automatic logic [16:0] atan_lut(input logic [4:0] k);
    logic [16:0] r;
    case (k)
      5'd0:    r = 17'd51472;
      5'd1:    r = 17'd30385;
      5'd2:    r = 17'd16055;
      5'd3:    r = 17'd8150;
      5'd4:    r = 17'd4091;
      5'd5:    r = 17'd2047;
      5'd6:    r = 17'd1024;
      5'd7:    r = 17'd512;
      5'd8:    r = 17'd256;
      5'd9:    r = 17'd128;
      5'd10:   r = 17'd64;
      5'd11:   r = 17'd32;
      5'd12:   r = 17'd16;
      5'd13:   r = 17'd8;
      5'd14:   r = 17'd4;
      5'd15:   r = 17'd2;
      5'd16:   r = 17'd1;
      default: r = 17'd0;
    endcase
    return r;
  endfunction

endpackage

>>> hdl/spge_ram.sv
// ----------------------------------------------------------------------------
// spge_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module spge_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

>>> hdl/spge_divsqrt.sv
// ----------------------------------------------------------------------------
// spge_divsqrt
// Shared bit-serial unit: 64-bit integer square root or 64/64 division.
// ----------------------------------------------------------------------------
module spge_divsqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        sqrt_i,
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  output logic        done_o,
  output logic [63:0] res_o
);

  logic [63:0] num_q, num_d, rem_q, rem_d, res_q, res_d, bit_q, bit_d, den_q, den_d;
  logic        busy_q, busy_d, sq_q, sq_d, done_d, done_q;
  logic [6:0]  cnt_q, cnt_d;
  logic [64:0] trial;
  logic [64:0] rsh;

  always_comb begin
    num_d = num_q; rem_d = rem_q; res_d = res_q; bit_d = bit_q; den_d = den_q;
    busy_d = busy_q; sq_d = sq_q; cnt_d = cnt_q; done_d = 1'b0;
    trial = '0;
    rsh = '0;
    if (start_i) begin
      busy_d = 1'b1; sq_d = sqrt_i; num_d = a_i; den_d = b_i;
      rem_d = '0; res_d = '0; bit_d = 64'h4000_0000_0000_0000;
      cnt_d = sqrt_i ? 7'd32 : 7'd64;
    end else if (busy_q) begin
      if (sq_q) begin
        // one result bit per cycle, classic digit-by-digit root
        trial = {1'b0, res_q} + {1'b0, bit_q};
        if ({1'b0, num_q} >= trial) begin
          num_d = num_q - trial[63:0];
          res_d = (res_q >> 1) + bit_q;
        end else begin
          res_d = res_q >> 1;
        end
        bit_d = bit_q >> 2;
      end else begin
        // restoring division, one quotient bit per cycle
        rsh = {rem_q, num_q[63]};
        num_d = {num_q[62:0], 1'b0};
        if (rsh >= {1'b0, den_q}) begin
          rem_d = rsh[63:0] - den_q;
          res_d = {res_q[62:0], 1'b1};
        end else begin
          rem_d = rsh[63:0];
          res_d = {res_q[62:0], 1'b0};
        end
      end
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0; sq_q <= 1'b0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d; sq_q <= sq_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d; rem_q <= rem_d; res_q <= res_d; bit_q <= bit_d; den_q <= den_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

>>> hdl/softened_potential_grid_eval.sv
// ----------------------------------------------------------------------------
// softened_potential_grid_eval
// Sums softened point-mass potential at one grid point and warps it by atan.
// ----------------------------------------------------------------------------
// Evaluate runs one square root and one division per stored body on the shared unit.
// Throughput: one command at a time; busy_o is high until the result strobe,
//   and the next command may be taken in the strobe cycle.
// The shared root/divide unit sets the rate; the receiver cannot stall.
// Reset: asynchronous, active low; empties the body table and loads register
//   defaults. Table RAM contents are not cleared.
module softened_potential_grid_eval #(
  parameter int unsigned MAX_BODIES = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [1:0]         cmd_i,
  input  logic signed [31:0] body_x_i,
  input  logic signed [31:0] body_z_i,
  input  logic [31:0]        body_mass_i,
  input  logic [8:0]         col_index_i,
  input  logic [8:0]         row_index_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  output logic               result_valid_o,
  output logic signed [31:0] point_x_o,
  output logic signed [31:0] point_z_o,
  output logic signed [20:0] height_o,
  output logic [1:0]         status_o
);

  localparam int unsigned AW = (MAX_BODIES > 1) ? $clog2(MAX_BODIES) : 1;
  localparam int unsigned CW = $clog2(MAX_BODIES + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_PX, S_PZ, S_RD, S_WAIT, S_SQ, S_SQRT, S_MUL, S_DIV, S_ACC,
    S_CORD, S_HGT, S_OUT
  } state_e;

  state_e state_q;
  logic [30:0] grav_q, step_q;
  logic [7:0]  half_q;
  logic [CW-1:0] count_q;
  logic [AW-1:0] idx_q;
  logic [8:0]  ci_q, ri_q;
  logic signed [31:0] px_q, pz_q;
  logic signed [32:0] dz_q;
  logic [63:0] acc_q;        // x offset squared, then G*m
  logic signed [32:0] sum_q; // range [-2^31, 0]
  logic signed [49:0] cx_q, cy_q;
  logic signed [17:0] cz_q;
  logic [4:0]  k_q;
  logic        neg_q;
  logic [20:0] h_q;
  logic        rv_q;
  logic [1:0]  st_q;

  // table RAMs
  logic        we;
  logic [AW-1:0] ram_addr;
  logic [31:0] rx, rz, rm;
  assign we = (state_q == S_IDLE) && start_i && (cmd_i == spge_pkg::CMD_ADD)
              && (count_q < CW'(MAX_BODIES));
  assign ram_addr = (state_q == S_IDLE) ? count_q[AW-1:0] : idx_q;

  spge_ram #(.WIDTH(32), .DEPTH(1 << AW)) u_rx (
    .clk_i, .we_i(we), .addr_i(ram_addr), .wdata_i(body_x_i), .rdata_o(rx));
  spge_ram #(.WIDTH(32), .DEPTH(1 << AW)) u_rz (
    .clk_i, .we_i(we), .addr_i(ram_addr), .wdata_i(body_z_i), .rdata_o(rz));
  spge_ram #(.WIDTH(32), .DEPTH(1 << AW)) u_rm (
    .clk_i, .we_i(we), .addr_i(ram_addr), .wdata_i(body_mass_i), .rdata_o(rm));

  // shared root / divide unit
  logic        du_start, du_sqrt, du_done;
  logic [63:0] du_a, du_b, du_res;
  spge_divsqrt u_du (
    .clk_i, .rst_ni, .start_i(du_start), .sqrt_i(du_sqrt),
    .a_i(du_a), .b_i(du_b), .done_o(du_done), .res_o(du_res));

  // grid coordinate: one signed multiply, saturate to 32 bits
  logic signed [9:0]  off;
  logic signed [41:0] prod;
  logic signed [31:0] psat;
  assign off  = (state_q == S_PX) ? $signed({1'b0, ci_q}) - $signed({2'b0, half_q})
                                  : $signed({1'b0, ri_q}) - $signed({2'b0, half_q});
  assign prod = off * $signed({1'b0, step_q});
  assign psat = (prod > 42'sd2147483647) ? 32'sh7fffffff :
                (prod < -42'sd2147483648) ? 32'sh80000000 : prod[31:0];

  // square with saturation
  logic signed [32:0] dsel;
  logic [32:0] mag;
  logic [63:0] sq;
  logic [64:0] sqsum;
  assign dsel = (state_q == S_WAIT) ? (33'(px_q) - 33'(signed'(rx))) : dz_q;
  assign mag  = dsel[32] ? 33'(-dsel) : 33'(dsel);
  assign sq   = mag[32] ? '1 : mag[31:0] * mag[31:0];
  assign sqsum = {1'b0, acc_q} + {1'b0, sq};

  // magnitude of the sum divided by five, by reciprocal multiply
  logic signed [32:0] nsum;
  logic [63:0] w5prod;
  logic [28:0] a5;
  assign nsum   = -sum_q;
  assign w5prod = {32'd0, nsum[31:0]} * {32'd0, spge_pkg::DIV5_RECIP};
  assign a5     = w5prod[62:34];

  // cordic step
  logic signed [49:0] xs, ys;
  logic signed [33:0] ssub;
  assign xs = cx_q >>> k_q;
  assign ys = cy_q >>> k_q;
  assign ssub = 34'(sum_q) - 34'(signed'({1'b0, du_res[32:0]}));

  localparam logic [37:0] HGAIN = 38'(spge_pkg::HEIGHT_GAIN);
  logic [37:0] hprod;
  assign hprod = cz_q[16:0] * HGAIN + 38'd32768;

  always_comb begin
    du_start = 1'b0; du_sqrt = 1'b1; du_a = acc_q; du_b = '0;
    case (state_q)
      S_SQ: begin
        du_start = 1'b1;
        du_a = (sqsum[64] || (sqsum[63:0] + spge_pkg::SOFTEN_Q32 < sqsum[63:0])) ? '1
               : sqsum[63:0] + spge_pkg::SOFTEN_Q32;
      end
      S_MUL: begin
        du_start = du_done; du_sqrt = 1'b0; du_a = acc_q; du_b = du_res;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; grav_q <= 31'd65536; half_q <= 8'd16; step_q <= 31'd65536;
      count_q <= '0; rv_q <= 1'b0; idx_q <= '0; k_q <= '0;
    end else begin
      rv_q <= 1'b0;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          spge_pkg::REG_GRAV: grav_q <= cfg_data_i[30:0];
          spge_pkg::REG_HALF: half_q <= cfg_data_i[7:0];
          spge_pkg::REG_STEP: step_q <= cfg_data_i[30:0];
          default: ;
        endcase
      end
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            ci_q <= col_index_i; ri_q <= row_index_i;
            px_q <= '0; pz_q <= '0; h_q <= '0; st_q <= spge_pkg::ST_OK;
            idx_q <= '0; sum_q <= '0; neg_q <= 1'b0;
            case (cmd_i)
              spge_pkg::CMD_CLEAR: begin count_q <= '0; state_q <= S_OUT; end
              spge_pkg::CMD_ADD: begin
                if (we) count_q <= count_q + CW'(1);
                else st_q <= spge_pkg::ST_FULL;
                state_q <= S_OUT;
              end
              spge_pkg::CMD_EVAL: begin
                if ({1'b0, col_index_i} > {1'b0, half_q, 1'b0} ||
                    {1'b0, row_index_i} > {1'b0, half_q, 1'b0}) begin
                  st_q <= spge_pkg::ST_RANGE; state_q <= S_OUT;
                end else state_q <= S_PX;
              end
              default: state_q <= S_OUT;
            endcase
          end
        end
        S_PX: begin px_q <= psat; state_q <= S_PZ; end
        S_PZ: begin
          pz_q <= psat;
          state_q <= (count_q == '0) ? S_OUT : S_RD;
        end
        S_RD: state_q <= S_WAIT;       // RAM read in flight
        S_WAIT: begin
          acc_q <= sq;
          dz_q <= 33'(pz_q) - 33'(signed'(rz));
          state_q <= S_SQ;
        end
        S_SQ: state_q <= S_SQRT;
        S_SQRT: begin
          acc_q <= 64'(grav_q) * 64'(rm);
          state_q <= S_MUL;
        end
        S_MUL: if (du_done) state_q <= S_DIV;
        S_DIV: if (du_done) begin
          // accumulate and saturate at -2^31
          if (du_res[63:31] != '0 || ssub < -34'sd2147483648) sum_q <= -33'sd2147483648;
          else sum_q <= ssub[32:0];
          if ({1'b0, idx_q} == CW'(count_q - CW'(1))) state_q <= S_ACC;
          else begin idx_q <= idx_q + AW'(1); state_q <= S_RD; end
        end
        S_ACC: begin
          neg_q <= (sum_q != '0);
          if (a5 == '0) state_q <= S_OUT;
          else begin
            cx_q <= 50'sd4294967296; cy_q <= 50'(a5) <<< 16;
            cz_q <= '0; k_q <= '0; state_q <= S_CORD;
          end
        end
        S_CORD: begin
          if (cy_q > 0) begin
            cx_q <= cx_q + ys; cy_q <= cy_q - xs;
            cz_q <= cz_q + 18'(spge_pkg::atan_lut(k_q));
          end else begin
            cx_q <= cx_q - ys; cy_q <= cy_q + xs;
            cz_q <= cz_q - 18'(spge_pkg::atan_lut(k_q));
          end
          k_q <= k_q + 5'd1;
          if (k_q == 5'(spge_pkg::CORDIC_ITERS - 1)) state_q <= S_HGT;
        end
        S_HGT: begin
          if (cz_q < 0) cz_q <= '0;
          else if (cz_q > 18'(spge_pkg::ANGLE_MAX)) cz_q <= 18'(spge_pkg::ANGLE_MAX);
          state_q <= S_OUT;
          k_q <= 5'd31; // mark height pending
        end
        S_OUT: begin
          if (k_q == 5'd31) begin
            h_q <= (hprod[37:16] > 22'(spge_pkg::HEIGHT_MAX)) ? spge_pkg::HEIGHT_MAX
                   : hprod[36:16];
            k_q <= '0;
          end else begin
            rv_q <= 1'b1; state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign result_valid_o = rv_q;
  assign point_x_o = px_q;
  assign point_z_o = pz_q;
  assign height_o  = neg_q ? -$signed(h_q) : $signed(h_q);
  assign status_o  = st_q;

`ifndef SYNTH
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_BODIES)) else $error("body count overflow");
  a_rv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy_o) else $error("strobe while busy");
  a_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o) else $error("command not taken");
`endif

endmodule
